/* src/pva_pkg.sv */
// Shared types, codes and sizes for the polyphonic voice allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package pva_pkg;

  localparam int VOICES_DEF = 8;
  localparam int KEYS_DEF   = 24;
  localparam int MASK_W     = 24;
  localparam int SLOT_W     = 5;
  localparam int CNT_W      = 6;
  localparam int AGE_W      = 32;

  // request codes
  localparam logic [2:0] REQ_START_INST   = 3'd0;
  localparam logic [2:0] REQ_START_SYNTH  = 3'd1;
  localparam logic [2:0] REQ_RELEASE      = 3'd2;
  localparam logic [2:0] REQ_LATCH_SYNTH  = 3'd3;
  localparam logic [2:0] REQ_REL_LATCHED  = 3'd4;
  localparam logic [2:0] REQ_CLEAR_LATCH  = 3'd5;
  localparam logic [2:0] REQ_CLEAR_ALL    = 3'd6;
  localparam logic [2:0] REQ_CHORD        = 3'd7;

  // result status codes
  localparam logic [1:0] ST_STARTED = 2'd0;
  localparam logic [1:0] ST_TOGGLED = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;
  localparam logic [1:0] ST_FAILED  = 2'd3;

  // datapath phase commands
  localparam logic [2:0] PH_NONE  = 3'd0;
  localparam logic [2:0] PH_SCAN  = 3'd1;
  localparam logic [2:0] PH_APPLY = 3'd2;
  localparam logic [2:0] PH_CLEAR = 3'd3;
  localparam logic [2:0] PH_CHORD = 3'd4;
  localparam logic [2:0] PH_SUM   = 3'd5;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [4:0]        key_index;
    logic [6:0]        base_note;
    logic              want_latch;
    logic              sustain;
    logic [MASK_W-1:0] chord_keys;
  } pva_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_used;
    logic [CNT_W-1:0]  op_count;
    logic [MASK_W-1:0] key_mask;
    logic [MASK_W-1:0] visible_mask;
    logic [CNT_W-1:0]  active_count;
    logic [CNT_W-1:0]  synth_active_count;
    logic [CNT_W-1:0]  synth_latched_count;
    logic [SLOT_W-1:0] newest_slot;
    logic              newest_valid;
  } pva_out_t;

  typedef struct packed {
    logic              load;
    logic [2:0]        phase;
    logic [SLOT_W-1:0] slot;
    logic [4:0]        key;
    logic              last;
  } pva_cmd_t;

  typedef struct packed {
    logic chord_empty;
    logic chord_fail;
  } pva_stat_t;

endpackage

`default_nettype wire

/* src/polyphonic_voice_allocator.sv */
// Top level of the polyphonic voice allocator: sequencer plus voice datapath.
// Depends on pva_pkg, pva_ctrl and pva_datapath.
`default_nettype none

// A request word is taken on a clock edge with start high and busy low; busy
// then stays high until the result word is out. The result sits on out_data
// for exactly one cycle with out_valid high and must be captured then; there
// is no way to hold it off. The sequencer walks the voice table one slot per
// cycle: a start request scans the table, writes the chosen slot, then sums
// the table; release/latch/clear requests scan and then sum; a chord clears
// the table, walks min(KEYS,24) keys and then sums, ending the key walk early
// if a key fails and skipping it if the mask is empty. A new
// request may be presented in the same cycle that out_valid is high.
module polyphonic_voice_allocator import pva_pkg::*; #(
  parameter int VOICES = VOICES_DEF,
  parameter int KEYS   = KEYS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire pva_in_t in_data,
  output logic         out_valid,
  output pva_out_t     out_data
);

  pva_cmd_t  cmd;
  pva_stat_t stat;

  pva_ctrl #(
    .VOICES (VOICES),
    .KEYS   (KEYS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_type  (in_data.req_type),
    .stat      (stat),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  pva_datapath #(
    .VOICES (VOICES),
    .KEYS   (KEYS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .stat     (stat),
    .out_data (out_data)
  );

  // a result only appears once the sequencer is back to idle
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // every result closes a request that was in flight
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a request");

  // an accepted word always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // one result per request: the strobe never repeats back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

endmodule

`default_nettype wire

/* src/pva_ctrl.sv */
// Sequencer for the voice allocator: walks slots and chord keys, issues phases.
// Depends on pva_pkg.
`default_nettype none

module pva_ctrl import pva_pkg::*; #(
  parameter int VOICES = VOICES_DEF,
  parameter int KEYS   = KEYS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [2:0] req_type,
  input  wire pva_stat_t  stat,
  output logic            busy,
  output logic            out_valid,
  output pva_cmd_t        cmd
);

  localparam int CHORD_N = (KEYS < MASK_W) ? KEYS : MASK_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_CLEAR = 3'd3;
  localparam logic [2:0] S_CHORD = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [4:0]        key_r, key_nxt;
  logic              is_start_r, is_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_last, key_last;

  assign slot_last = (slot_r == SLOT_W'(VOICES - 1));
  assign key_last  = (key_r == 5'(CHORD_N - 1));

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    key_nxt       = key_r;
    is_start_nxt  = is_start_r;
    out_valid_nxt = 1'b0;
    cmd.load      = 1'b0;
    cmd.phase     = PH_NONE;
    cmd.slot      = slot_r;
    cmd.key       = key_r;
    cmd.last      = slot_last;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          slot_nxt     = '0;
          key_nxt      = '0;
          is_start_nxt = (req_type == REQ_START_INST) || (req_type == REQ_START_SYNTH);
          state_nxt    = (req_type == REQ_CHORD) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.phase = PH_SCAN;
        if (slot_last) begin
          slot_nxt  = '0;
          state_nxt = is_start_r ? S_APPLY : S_SUM;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      S_APPLY: begin
        cmd.phase = PH_APPLY;
        state_nxt = S_SUM;
      end
      S_CLEAR: begin
        cmd.phase = PH_CLEAR;
        state_nxt = stat.chord_empty ? S_SUM : S_CHORD;
      end
      S_CHORD: begin
        cmd.phase = PH_CHORD;
        if (stat.chord_fail || key_last) begin
          state_nxt = S_SUM;
        end else begin
          key_nxt = key_r + 1'b1;
        end
      end
      S_SUM: begin
        cmd.phase = PH_SUM;
        if (slot_last) begin
          slot_nxt      = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      key_r       <= '0;
      is_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      key_r       <= key_nxt;
      is_start_r  <= is_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/pva_datapath.sv */
// Voice table, per-slot scan logic, chord loader and result accumulators.
// Depends on pva_pkg; driven by pva_ctrl commands.
`default_nettype none

module pva_datapath import pva_pkg::*; #(
  parameter int VOICES = VOICES_DEF,
  parameter int KEYS   = KEYS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire pva_cmd_t cmd,
  input  wire pva_in_t  in_data,
  output pva_stat_t     stat,
  output pva_out_t      out_data
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // voice table
  logic             act_r  [VOICES];
  logic             lat_r  [VOICES];
  logic             syn_r  [VOICES];
  logic             loop_r [VOICES];
  logic [4:0]       key_r  [VOICES];
  logic [6:0]       midi_r [VOICES];
  logic [AGE_W-1:0] age_r  [VOICES];
  logic [AGE_W-1:0] age_cnt_r;

  pva_in_t          req_r;

  // start search
  logic             hit_r, hit_lat_r, free_r;
  logic [IDX_W-1:0] hit_idx_r, free_idx_r;

  // result words
  logic [1:0]        status_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  count_r;
  logic [MASK_W-1:0] kmask_r, vmask_r;
  logic [CNT_W-1:0]  act_cnt_r, sact_r, slat_r;
  logic [SLOT_W-1:0] newest_r;
  logic              nvalid_r;
  logic [AGE_W-1:0]  newest_age_r;

  logic [IDX_W-1:0] ridx;
  logic             rd_act, rd_lat, rd_syn, rd_loop;
  logic [4:0]       rd_key;
  logic [6:0]       rd_midi;
  logic [AGE_W-1:0] rd_age;

  logic [7:0]       midi_in, cmidi;
  logic             is_start, is_synth, bad_key, match;
  logic             cbit, chord_fail;
  logic [IDX_W-1:0] pick_idx, chord_idx;
  logic [6:0]       vdiff;
  logic             kok, vok, newer;
  logic [31:0]      kadd, vadd;

  assign ridx    = cmd.slot[IDX_W-1:0];
  assign rd_act  = act_r[ridx];
  assign rd_lat  = lat_r[ridx];
  assign rd_syn  = syn_r[ridx];
  assign rd_loop = loop_r[ridx];
  assign rd_key  = key_r[ridx];
  assign rd_midi = midi_r[ridx];
  assign rd_age  = age_r[ridx];

  assign is_start = (req_r.req_type == REQ_START_INST) || (req_r.req_type == REQ_START_SYNTH);
  assign is_synth = (req_r.req_type == REQ_START_SYNTH);
  assign midi_in  = {1'b0, req_r.base_note} + {3'b000, req_r.key_index};
  assign bad_key  = ({1'b0, req_r.key_index} >= 6'(KEYS)) || midi_in[7];
  assign match    = rd_act && (!is_synth || rd_syn) && (rd_key == req_r.key_index) &&
                    (rd_midi == midi_in[6:0]);
  assign pick_idx = hit_r ? hit_idx_r : free_idx_r;

  // chord: one key per cycle, voices fill slots in order after the clear
  assign cbit       = req_r.chord_keys[cmd.key];
  assign cmidi      = {1'b0, req_r.base_note} + {3'b000, cmd.key};
  assign chord_fail = (cmd.phase == PH_CHORD) && cbit &&
                      ((count_r >= CNT_W'(VOICES)) || cmidi[7]);
  assign chord_idx  = count_r[IDX_W-1:0];

  assign stat.chord_empty = (req_r.chord_keys == '0);
  assign stat.chord_fail  = chord_fail;

  // summary terms for the slot under scan
  assign kok   = ({1'b0, rd_key} < 6'(KEYS));
  assign kadd  = kok ? (32'd1 << rd_key) : 32'd0;
  assign vdiff = rd_midi - req_r.base_note;
  assign vok   = (rd_midi >= req_r.base_note) && ({1'b0, vdiff} < 8'(KEYS));
  assign vadd  = vok ? (32'd1 << vdiff[4:0]) : 32'd0;
  assign newer = !nvalid_r || (rd_age > newest_age_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) begin
        act_r[i] <= 1'b0;
      end
      age_cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        req_r        <= in_data;
        status_r     <= ST_STARTED;
        slot_r       <= '0;
        count_r      <= '0;
        hit_r        <= 1'b0;
        free_r       <= 1'b0;
        kmask_r      <= '0;
        vmask_r      <= '0;
        act_cnt_r    <= '0;
        sact_r       <= '0;
        slat_r       <= '0;
        newest_r     <= '0;
        nvalid_r     <= 1'b0;
        newest_age_r <= '0;
      end
      case (cmd.phase)
        PH_SCAN: begin
          if (is_start) begin
            // first match ends the search; first free slot before it is kept
            if (!hit_r) begin
              if (match) begin
                hit_r     <= 1'b1;
                hit_idx_r <= ridx;
                hit_lat_r <= rd_lat;
              end else if (!rd_act && !free_r) begin
                free_r     <= 1'b1;
                free_idx_r <= ridx;
              end
            end
          end else begin
            case (req_r.req_type)
              REQ_RELEASE: begin
                if (rd_act && !rd_lat && rd_loop && (rd_key == req_r.key_index)) begin
                  act_r[ridx] <= 1'b0;
                  count_r     <= count_r + 1'b1;
                end
              end
              REQ_LATCH_SYNTH: begin
                if (rd_act && rd_syn) begin
                  lat_r[ridx] <= 1'b1;
                  count_r     <= count_r + 1'b1;
                end
              end
              REQ_REL_LATCHED: begin
                if (rd_act && rd_syn && rd_lat) begin
                  act_r[ridx] <= 1'b0;
                  count_r     <= count_r + 1'b1;
                end
              end
              REQ_CLEAR_LATCH: begin
                if (rd_act && rd_lat) begin
                  act_r[ridx] <= 1'b0;
                  count_r     <= count_r + 1'b1;
                end
              end
              REQ_CLEAR_ALL: begin
                if (rd_act) begin
                  count_r <= count_r + 1'b1;
                end
                if (cmd.last) begin
                  for (int i = 0; i < VOICES; i++) begin
                    act_r[i] <= 1'b0;
                  end
                  age_cnt_r <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        PH_APPLY: begin
          if (bad_key) begin
            status_r <= ST_FAILED;
          end else if (hit_r && hit_lat_r) begin
            slot_r <= SLOT_W'(hit_idx_r);
            if (req_r.want_latch) begin
              act_r[hit_idx_r] <= 1'b0;
              status_r         <= ST_TOGGLED;
            end
          end else if (hit_r || free_r) begin
            act_r[pick_idx]  <= 1'b1;
            lat_r[pick_idx]  <= req_r.want_latch;
            syn_r[pick_idx]  <= is_synth;
            loop_r[pick_idx] <= is_synth | req_r.sustain;
            key_r[pick_idx]  <= req_r.key_index;
            midi_r[pick_idx] <= midi_in[6:0];
            age_r[pick_idx]  <= age_cnt_r + 1'b1;
            age_cnt_r        <= age_cnt_r + 1'b1;
            slot_r           <= SLOT_W'(pick_idx);
          end else begin
            status_r <= ST_LIMIT;
          end
        end
        PH_CLEAR: begin
          if (stat.chord_empty) begin
            status_r <= ST_FAILED;
          end else begin
            for (int i = 0; i < VOICES; i++) begin
              act_r[i] <= 1'b0;
            end
            age_cnt_r <= '0;
          end
        end
        PH_CHORD: begin
          if (chord_fail) begin
            // all or nothing: drop every voice this chord placed
            for (int i = 0; i < VOICES; i++) begin
              act_r[i] <= 1'b0;
            end
            age_cnt_r <= '0;
            count_r   <= '0;
            status_r  <= ST_FAILED;
          end else if (cbit) begin
            act_r[chord_idx]  <= 1'b1;
            lat_r[chord_idx]  <= 1'b1;
            syn_r[chord_idx]  <= 1'b0;
            loop_r[chord_idx] <= req_r.sustain;
            key_r[chord_idx]  <= cmd.key;
            midi_r[chord_idx] <= cmidi[6:0];
            age_r[chord_idx]  <= age_cnt_r + 1'b1;
            age_cnt_r         <= age_cnt_r + 1'b1;
            count_r           <= count_r + 1'b1;
          end
        end
        PH_SUM: begin
          if (rd_act) begin
            act_cnt_r <= act_cnt_r + 1'b1;
            if (rd_syn) begin
              sact_r <= sact_r + 1'b1;
              if (rd_lat) begin
                slat_r <= slat_r + 1'b1;
              end
            end
            kmask_r <= kmask_r | kadd[MASK_W-1:0];
            vmask_r <= vmask_r | vadd[MASK_W-1:0];
            if (newer) begin
              newest_r     <= SLOT_W'(ridx);
              newest_age_r <= rd_age;
              nvalid_r     <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_data.status              = status_r;
  assign out_data.slot_used           = slot_r;
  assign out_data.op_count            = count_r;
  assign out_data.key_mask            = kmask_r;
  assign out_data.visible_mask        = vmask_r;
  assign out_data.active_count        = act_cnt_r;
  assign out_data.synth_active_count  = sact_r;
  assign out_data.synth_latched_count = slat_r;
  assign out_data.newest_slot         = newest_r;
  assign out_data.newest_valid        = nvalid_r;

endmodule

`default_nettype wire
